// File: design/lzss_pkg.sv
// Shared types and constants for the LZSS stream compressor.
// Used by lzss_group, lzss_stream_compressor and the testbench; depends on nothing else.
package lzss_pkg;

	localparam int GROUP_ITEMS = 8;
	localparam int GROUP_BYTES = 2 * GROUP_ITEMS;
	localparam int OFFSET_W    = 12;
	localparam int LEN_W       = 4;
	localparam int LEN_BIAS    = 3;

	// request from the sequencer to the group packer
	typedef struct packed {
		logic       add;
		logic       drain;
		logic       literal;
		logic       last;
		logic [7:0] b0;
		logic [7:0] b1;
	} grp_cmd_t;

	typedef struct packed {
		logic busy;
		logic has_items;
	} grp_stat_t;

endpackage

// File: design/lzss_window.sv
// Ring window memory: one write port, one registered read port.
// A read with rzero set returns zero; the top sets it for unwritten entries. No package dependency.
module lzss_window #(
	parameter int WINDOW_SIZE = 4096,
	parameter int AW = $clog2(WINDOW_SIZE)
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [7:0]    wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	input  logic          rzero,
	output logic [7:0]    rdata
);

	logic [7:0] mem [WINDOW_SIZE];
	logic [7:0] raw_q;
	logic       zero_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			raw_q <= mem[raddr];
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			zero_q <= rzero;
		end
	end

	assign rdata = zero_q ? 8'd0 : raw_q;

endmodule

// File: design/lzss_match.sv
// Shared compare unit: shift line of the last window bytes read, compared
// against the pending string. No package dependency.
module lzss_match #(
	parameter int WINDOW_SIZE = 4096,
	parameter int MAX_MATCH = 18,
	parameter int AW = $clog2(WINDOW_SIZE),
	parameter int NW = $clog2(MAX_MATCH + 1)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          shift_en,
	input  logic [7:0]    rd_byte,
	input  logic [AW-1:0] pos_s1,
	input  logic [7:0]    pending [MAX_MATCH],
	input  logic [NW-1:0] match_len,
	output logic          valid,
	output logic          hit,
	output logic          at_end,
	output logic [AW-1:0] offset
);

	logic [7:0]    line_q [MAX_MATCH];
	logic [AW-1:0] pos_s2;
	logic          valid_s2;

	always_ff @(posedge clk) begin
		if (shift_en) begin
			line_q[0] <= rd_byte;
			for (int k = 1; k < MAX_MATCH; k++) begin
				line_q[k] <= line_q[k-1];
			end
			pos_s2 <= pos_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= shift_en;
		end
	end

	// line_q[m] holds the byte m places before the newest one read
	always_comb begin
		hit = valid_s2 && (int'(pos_s2) >= int'(match_len) - 1);
		for (int m = 0; m < MAX_MATCH; m++) begin
			if (m < int'(match_len)) begin
				if (line_q[m] != pending[int'(match_len) - 1 - m]) begin
					hit = 1'b0;
				end
			end
		end
	end

	assign valid  = valid_s2;
	assign at_end = valid_s2 && (int'(pos_s2) == WINDOW_SIZE - 1);
	assign offset = AW'(int'(pos_s2) - int'(match_len) + 1);

endmodule

// File: design/lzss_group.sv
// Group packer: collects items, then sends flag byte and item bytes through
// the output register. Depends on lzss_pkg.
module lzss_group (
	input  logic                clk,
	input  logic                arst_n,
	input  lzss_pkg::grp_cmd_t  cmd,
	output lzss_pkg::grp_stat_t stat,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [7:0]          out_byte,
	output logic                out_last
);

	typedef enum logic [1:0] {G_IDLE, G_FLAG, G_BYTES} gstate_t;

	gstate_t            state_q;
	logic [4:0]         cnt_q;
	logic [3:0]         items_q;
	logic [7:0]         flags_q;
	logic [3:0]         idx_q;
	logic               dlast_q;
	logic               then_add_q;
	lzss_pkg::grp_cmd_t hold_q;
	logic               ovalid_q;
	logic [7:0]         obyte_q;
	logic               olast_q;
	logic [7:0]         bytes_q [lzss_pkg::GROUP_BYTES];

	logic               slot, full, last_idx, clear, add_go;
	lzss_pkg::grp_cmd_t add_cmd;
	logic [4:0]         base_cnt, new_cnt;
	logic [3:0]         base_items;
	logic [7:0]         base_flags, new_flags;

	assign slot     = !ovalid_q || !out_stall;
	assign full     = items_q == 4'(lzss_pkg::GROUP_ITEMS);
	assign last_idx = {1'b0, idx_q} == cnt_q - 5'd1;
	assign clear    = (state_q == G_BYTES) && slot && last_idx;
	assign add_go   = (state_q == G_IDLE && cmd.add && !full) || (clear && then_add_q);
	assign add_cmd  = (state_q == G_BYTES) ? hold_q : cmd;

	always_comb begin
		base_cnt   = clear ? 5'd0 : cnt_q;
		base_items = clear ? 4'd0 : items_q;
		base_flags = clear ? 8'd0 : flags_q;
		new_cnt    = base_cnt + (add_cmd.literal ? 5'd1 : 5'd2);
		new_flags  = base_flags | (8'(add_cmd.literal) << base_items[2:0]);
	end

	always_ff @(posedge clk) begin
		if (add_go) begin
			bytes_q[base_cnt[3:0]] <= add_cmd.b0;
			if (!add_cmd.literal) begin
				bytes_q[4'(base_cnt + 5'd1)] <= add_cmd.b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= G_IDLE;
			cnt_q      <= '0;
			items_q    <= '0;
			flags_q    <= '0;
			idx_q      <= '0;
			dlast_q    <= 1'b0;
			then_add_q <= 1'b0;
			hold_q     <= '0;
			ovalid_q   <= 1'b0;
			obyte_q    <= '0;
			olast_q    <= 1'b0;
		end else begin
			if (slot) begin
				ovalid_q <= 1'b0;
			end
			case (state_q)
				G_IDLE: begin
					if (cmd.add && full) begin
						hold_q     <= cmd;
						then_add_q <= 1'b1;
						dlast_q    <= 1'b0;
						state_q    <= G_FLAG;
					end else if (cmd.drain && (full || (cmd.last && items_q != 4'd0))) begin
						// a plain drain sends only a full group, a last one any tail
						then_add_q <= 1'b0;
						dlast_q    <= cmd.last;
						state_q    <= G_FLAG;
					end
				end
				G_FLAG: begin
					if (slot) begin
						ovalid_q <= 1'b1;
						obyte_q  <= flags_q;
						olast_q  <= 1'b0;
						idx_q    <= '0;
						state_q  <= G_BYTES;
					end
				end
				G_BYTES: begin
					if (slot) begin
						ovalid_q <= 1'b1;
						obyte_q  <= bytes_q[idx_q];
						olast_q  <= dlast_q && last_idx;
						idx_q    <= idx_q + 4'd1;
						if (last_idx) begin
							state_q <= G_IDLE;
						end
					end
				end
				default: state_q <= G_IDLE;
			endcase
			if (clear) begin
				cnt_q   <= '0;
				items_q <= '0;
				flags_q <= '0;
			end
			if (add_go) begin
				cnt_q   <= new_cnt;
				items_q <= base_items + 4'd1;
				flags_q <= new_flags;
			end
		end
	end

	assign stat.busy      = state_q != G_IDLE;
	assign stat.has_items = items_q != 4'd0;
	assign out_valid      = ovalid_q;
	assign out_byte       = obyte_q;
	assign out_last       = olast_q;

endmodule

// File: design/lzss_stream_compressor.sv
// Greedy LZSS compressor, top level: sequencer around one window scan unit.
// A scan reads the window one entry a cycle and stops at the earliest match.
// A word takes one to three scans, writes its emitted bytes back one per cycle,
// and waits while the group packer sends. in_stall holds meanwhile.
// Reset (arst_n low) empties pending and group state; unwritten entries read as 0.
module lzss_stream_compressor #(
	parameter int WINDOW_SIZE = 4096,
	parameter int MAX_MATCH = 18
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] data_byte,
	input  logic       last_byte,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] out_byte,
	output logic       out_last
);

	localparam int AW = $clog2(WINDOW_SIZE);
	localparam int NW = $clog2(MAX_MATCH + 1);
	localparam int PW = $clog2(MAX_MATCH);

	typedef enum logic [3:0] {
		S_IDLE, S_LOAD, S_SCAN, S_DECIDE, S_GWAIT, S_PUSH, S_DONE, S_FLUSH, S_FWAIT
	} state_t;

	state_t                        state_q;
	logic [7:0]                    b_q;
	logic                          last_q;
	logic                          flush_q;
	logic [NW-1:0]                 pc_q;        // pending byte count
	logic [NW-1:0]                 n_q;         // length under search
	logic [lzss_pkg::OFFSET_W-1:0] off_q;       // earliest start of pending string
	logic [AW-1:0]                 wp_q;
	logic                          wrapped_q;
	logic [AW-1:0]                 raddr_q;
	logic [AW-1:0]                 iss_q;
	logic                          iss_on_q;
	logic                          rd_s1;
	logic [AW-1:0]                 pos_s1;
	logic                          tok_q;
	logic [NW-1:0]                 push_len_q;
	logic [PW-1:0]                 pidx_q;
	logic [7:0]                    pending_q [MAX_MATCH];

	logic                          issue, push_we, push_end;
	logic                          m_valid, m_hit, m_end;
	logic [AW-1:0]                 m_off;
	logic [AW-1:0]                 wp_inc, raddr_inc;
	logic [7:0]                    rd_byte;
	logic [lzss_pkg::LEN_W-1:0]    len_code;
	lzss_pkg::grp_cmd_t            gcmd;
	lzss_pkg::grp_stat_t           gstat;

	assign in_stall  = state_q != S_IDLE;
	assign issue     = (state_q == S_SCAN) && iss_on_q;
	assign push_we   = state_q == S_PUSH;
	assign push_end  = push_we && ({1'b0, pidx_q} == (PW + 1)'(push_len_q - NW'(1)));
	assign wp_inc    = (int'(wp_q) == WINDOW_SIZE - 1) ? '0 : wp_q + AW'(1);
	assign raddr_inc = (int'(raddr_q) == WINDOW_SIZE - 1) ? '0 : raddr_q + AW'(1);
	assign len_code  = lzss_pkg::LEN_W'(pc_q - NW'(lzss_pkg::LEN_BIAS));

	lzss_window #(.WINDOW_SIZE(WINDOW_SIZE), .AW(AW)) u_window (
		.clk   (clk),
		.we    (push_we),
		.waddr (wp_q),
		.wdata (pending_q[pidx_q]),
		.re    (issue),
		.raddr (raddr_q),
		.rzero (!(wrapped_q || raddr_q < wp_q)),
		.rdata (rd_byte)
	);

	lzss_match #(.WINDOW_SIZE(WINDOW_SIZE), .MAX_MATCH(MAX_MATCH), .AW(AW), .NW(NW)) u_match (
		.clk       (clk),
		.arst_n    (arst_n),
		.shift_en  (rd_s1 && state_q == S_SCAN),
		.rd_byte   (rd_byte),
		.pos_s1    (pos_s1),
		.pending   (pending_q),
		.match_len (n_q),
		.valid     (m_valid),
		.hit       (m_hit),
		.at_end    (m_end),
		.offset    (m_off)
	);

	// Group packer requests: add an item on decide, send a group that filled
	// up during this word when it is done, drain the tail on flush.
	always_comb begin
		gcmd = '0;
		if (state_q == S_DECIDE) begin
			gcmd.add = 1'b1;
			if (pc_q >= NW'(lzss_pkg::LEN_BIAS)) begin
				gcmd.literal = 1'b0;
				gcmd.b0      = off_q[7:0];
				gcmd.b1      = {len_code, off_q[lzss_pkg::OFFSET_W-1:8]};
			end else begin
				gcmd.literal = 1'b1;
				gcmd.b0      = pending_q[0];
			end
		end else if (state_q == S_DONE && !last_q) begin
			gcmd.drain = 1'b1;
		end else if (state_q == S_FLUSH && pc_q == '0 && gstat.has_items) begin
			gcmd.drain = 1'b1;
			gcmd.last  = 1'b1;
		end
	end

	lzss_group u_group (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (gcmd),
		.stat      (gstat),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_byte  (out_byte),
		.out_last  (out_last)
	);

	// Pending string: append the new byte, drop the head after a literal.
	always_ff @(posedge clk) begin
		if (state_q == S_LOAD && pc_q < NW'(MAX_MATCH)) begin
			pending_q[pc_q[PW-1:0]] <= b_q;
		end else if (push_end && !tok_q && pc_q != '0) begin
			for (int k = 0; k < MAX_MATCH - 1; k++) begin
				pending_q[k] <= pending_q[k+1];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			b_q        <= '0;
			last_q     <= 1'b0;
			flush_q    <= 1'b0;
			pc_q       <= '0;
			n_q        <= '0;
			off_q      <= '0;
			wp_q       <= '0;
			wrapped_q  <= 1'b0;
			raddr_q    <= '0;
			iss_q      <= '0;
			iss_on_q   <= 1'b0;
			rd_s1      <= 1'b0;
			pos_s1     <= '0;
			tok_q      <= 1'b0;
			push_len_q <= '0;
			pidx_q     <= '0;
		end else begin
			rd_s1  <= issue;
			pos_s1 <= iss_q;
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						b_q     <= data_byte;
						last_q  <= last_byte;
						state_q <= S_LOAD;
					end
				end
				S_LOAD: begin
					// full pending string cannot grow: go straight to emission
					if (pc_q < NW'(MAX_MATCH)) begin
						n_q      <= pc_q + NW'(1);
						raddr_q  <= wp_q;
						iss_q    <= '0;
						iss_on_q <= 1'b1;
						state_q  <= S_SCAN;
					end else begin
						state_q <= S_DECIDE;
					end
				end
				S_SCAN: begin
					if (issue) begin
						raddr_q <= raddr_inc;
						iss_q   <= iss_q + AW'(1);
						if (int'(iss_q) == WINDOW_SIZE - 1) begin
							iss_on_q <= 1'b0;
						end
					end
					if (m_valid && m_hit) begin
						iss_on_q <= 1'b0;
						off_q    <= lzss_pkg::OFFSET_W'(m_off);
						pc_q     <= pc_q + NW'(1);
						state_q  <= S_DONE;
					end else if (m_end) begin
						iss_on_q <= 1'b0;
						state_q  <= S_DECIDE;
					end
				end
				S_DECIDE: begin
					pidx_q <= '0;
					if (pc_q >= NW'(lzss_pkg::LEN_BIAS)) begin
						tok_q      <= 1'b1;
						push_len_q <= pc_q;
					end else begin
						tok_q      <= 1'b0;
						push_len_q <= NW'(1);
					end
					state_q <= S_GWAIT;
				end
				S_GWAIT: begin
					if (!gstat.busy) begin
						state_q <= S_PUSH;
					end
				end
				S_PUSH: begin
					// write back emitted bytes, oldest entry is overwritten
					wp_q   <= wp_inc;
					pidx_q <= pidx_q + PW'(1);
					if (int'(wp_q) == WINDOW_SIZE - 1) begin
						wrapped_q <= 1'b1;
					end
					if (push_end) begin
						if (tok_q) begin
							pc_q <= '0;
						end else if (pc_q != '0) begin
							pc_q <= pc_q - NW'(1);
						end
						if (flush_q) begin
							state_q <= S_FLUSH;
						end else if (tok_q || pc_q != '0) begin
							state_q <= S_LOAD;
						end else begin
							state_q <= S_DONE;
						end
					end
				end
				S_DONE: begin
					// hold the input until a group completed by this word is sent
					if (last_q) begin
						flush_q <= 1'b1;
						state_q <= S_FLUSH;
					end else begin
						state_q <= S_FWAIT;
					end
				end
				S_FLUSH: begin
					if (pc_q != '0) begin
						state_q <= S_DECIDE;
					end else if (gstat.has_items) begin
						state_q <= S_FWAIT;
					end else begin
						flush_q <= 1'b0;
						state_q <= S_IDLE;
					end
				end
				S_FWAIT: begin
					if (!gstat.busy) begin
						flush_q <= 1'b0;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// File: tb/sv/tb_lzss_stream_compressor.sv
// Self-checking testbench for lzss_stream_compressor: directed and random byte streams,
// with every compressed word checked against a behavioral LZSS predictor held here.
// Depends on lzss_pkg and the compressor RTL only.
module tb_lzss_stream_compressor;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int WIN      = 4096;
	localparam int MAXLEN   = 18;
	localparam int TAIL_CYC = 13000;     // one word can take about three window scans
	localparam int LONG_HOLD = 60000;    // receiver hold-off, long enough to back up the block
	localparam int N_RANDOM = 140;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_stall;
	logic [7:0] data_byte = 8'h00;
	logic       last_byte = 1'b0;
	logic       out_valid;
	logic       out_stall = 1'b0;
	logic [7:0] out_byte;
	logic       out_last;

	lzss_stream_compressor dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.data_byte(data_byte), .last_byte(last_byte),
		.out_valid(out_valid), .out_stall(out_stall),
		.out_byte(out_byte), .out_last(out_last)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	initial begin
		#150ms;
		$display("tb_lzss_stream_compressor failed");
		$finish;
	end

	// ---------------------------------------------------------------------
	// Predictor state: window, pending string, open flag group, and the
	// compressed words still owed by the block.
	// ---------------------------------------------------------------------
	typedef struct {
		logic [7:0] b;
		logic       last;
	} cword_t;

	logic [7:0] win_mem [WIN];
	logic [11:0] win_ptr;
	logic [7:0] pend [MAXLEN];
	int         pend_cnt;
	logic [7:0] grp_q [$];
	logic [7:0] grp_flags;
	int         grp_items;
	cword_t     owed_q [$];

	int  errors = 0;
	bit  quiet_phase = 1'b0;   // no idling on either side
	int  long_hold = 0;        // cycles of forced receiver stall left

	task automatic report(input string what);
		errors++;
		$display("%0t mismatch: %s", $realtime, what);
	endtask

	// Earliest match of the first n pending bytes, counted from the oldest entry.
	function automatic int earliest_match(input int n);
		int k;
		for (int i = 0; i + n <= WIN; i++) begin
			for (k = 0; k < n; k++)
				if (win_mem[12'(win_ptr + i + k)] != pend[k])
					break;
			if (k == n)
				return i;
		end
		return -1;
	endfunction

	task automatic win_push(input logic [7:0] b);
		win_mem[win_ptr] = b;
		win_ptr++;
	endtask

	task automatic close_group();
		owed_q.push_back('{grp_flags, 1'b0});
		foreach (grp_q[k])
			owed_q.push_back('{grp_q[k], 1'b0});
		grp_q.delete();
		grp_flags = '0;
		grp_items = 0;
	endtask

	task automatic add_item(input bit lit, input logic [7:0] b0, input logic [7:0] b1);
		if (lit)
			grp_flags[grp_items] = 1'b1;
		grp_q.push_back(b0);
		if (!lit)
			grp_q.push_back(b1);
		grp_items++;
		if (grp_items == lzss_pkg::GROUP_ITEMS)
			close_group();
	endtask

	task automatic put_token();
		int off;
		logic [15:0] tok;
		off = earliest_match(pend_cnt);
		if (off < 0)
			off = 0;
		tok = {4'(pend_cnt - lzss_pkg::LEN_BIAS), 12'(off)};
		add_item(1'b0, tok[7:0], tok[15:8]);
		for (int k = 0; k < pend_cnt; k++)
			win_push(pend[k]);
		pend_cnt = 0;
	endtask

	task automatic put_first_literal();
		add_item(1'b1, pend[0], 8'h00);
		win_push(pend[0]);
		for (int k = 0; k < MAXLEN - 1; k++)
			pend[k] = pend[k + 1];
		pend_cnt--;
	endtask

	// Compress one accepted word; the owed words grow by what it produces.
	task automatic compress_word(input logic [7:0] b, input logic last);
		forever begin
			if (pend_cnt < MAXLEN) begin
				pend[pend_cnt] = b;
				if (earliest_match(pend_cnt + 1) >= 0) begin
					pend_cnt++;
					break;
				end
			end
			if (pend_cnt >= 3)
				put_token();
			else if (pend_cnt == 0) begin
				add_item(1'b1, b, 8'h00);
				win_push(b);
				break;
			end else
				put_first_literal();
		end
		if (last) begin
			if (pend_cnt >= 3)
				put_token();
			while (pend_cnt > 0)
				put_first_literal();
			if (grp_items > 0)
				close_group();
			if (owed_q.size() > 0)
				owed_q[owed_q.size() - 1].last = 1'b1;
		end
	endtask

	// ---------------------------------------------------------------------
	// Directed table. A row with nexp >= 0 also carries the words it must
	// produce, typed in; the predictor is held to those.
	// ---------------------------------------------------------------------
	typedef struct {
		logic [7:0] b;
		logic       last;
		int         nexp;
		logic [7:0] e [4];
	} drow_t;

	localparam int N_DIR = 24;
	drow_t dir_tab [N_DIR];

	initial begin
		// single zero after reset: literal in a one-item group
		dir_tab[0]  = '{8'h00, 1, 2, '{8'h01, 8'h00, 8'h00, 8'h00}};
		// 19 zeros: token of the longest length at offset 0, then a flushed literal
		for (int i = 1; i <= 18; i++)
			dir_tab[i] = '{8'h00, 0, -1, '{default: 8'h00}};
		dir_tab[19] = '{8'h00, 1, 4, '{8'h02, 8'h00, 8'hF0, 8'h00}};
		// all-ones byte never seen before: plain literal
		dir_tab[20] = '{8'hFF, 1, 2, '{8'h01, 8'hFF, 8'h00, 8'h00}};
		dir_tab[21] = '{8'hAA, 0, -1, '{default: 8'h00}};
		dir_tab[22] = '{8'hCC, 0, -1, '{default: 8'h00}};
		dir_tab[23] = '{8'hF0, 1, -1, '{default: 8'h00}};
	end

	// ---------------------------------------------------------------------
	// Sender: drive at the falling edge, take the word at the rising edge
	// where it was accepted, predict right there.
	// ---------------------------------------------------------------------
	task automatic send_word(input logic [7:0] b, input logic last, input bit may_gap);
		if (may_gap && !quiet_phase && $urandom_range(0, 3) == 0) begin
			in_valid = 1'b0;
			repeat ($urandom_range(1, 3)) @(negedge clk);
		end
		in_valid  = 1'b1;
		data_byte = b;
		last_byte = last;
		do
			@(posedge clk);
		while (in_stall);
		compress_word(b, last);
		@(negedge clk);
		in_valid = 1'b0;
	endtask

	task automatic wait_drained();
		while (owed_q.size() > 0)
			@(negedge clk);
	endtask

	logic [7:0] recent [$];

	initial begin
		int base, len, mode, src;
		logic [7:0] b;

		foreach (win_mem[i])
			win_mem[i] = 8'h00;
		win_ptr = '0;
		pend_cnt = 0;
		grp_flags = '0;
		grp_items = 0;

		repeat (4) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed part, back to back, typed rows cross-checked
		foreach (dir_tab[r]) begin
			// let earlier words leave so the typed row sees only its own words
			if (dir_tab[r].nexp >= 0)
				wait_drained();
			base = owed_q.size();
			send_word(dir_tab[r].b, dir_tab[r].last, 1'b0);
			if (dir_tab[r].nexp >= 0) begin
				if (owed_q.size() - base != dir_tab[r].nexp)
					report($sformatf("row %0d produced %0d words, table says %0d",
						r, owed_q.size() - base, dir_tab[r].nexp));
				else
					for (int k = 0; k < dir_tab[r].nexp; k++)
						if (owed_q[base + k].b != dir_tab[r].e[k])
							report($sformatf("row %0d word %0d: %h, table says %h",
								r, k, owed_q[base + k].b, dir_tab[r].e[k]));
			end
		end
		// repeat the tail pattern so it comes back as a token
		send_word(8'hAA, 0, 1'b0);
		send_word(8'hCC, 0, 1'b0);
		send_word(8'hF0, 1, 1'b0);

		// hold the sender until every owed word is out
		wait_drained();

		// random streams; the receiver backs up once while words keep coming
		long_hold = LONG_HOLD;
		for (int n = 0; n < N_RANDOM; ) begin
			quiet_phase = (n > N_RANDOM - 30);
			len  = $urandom_range(1, 20);
			mode = $urandom_range(0, 9);
			for (int k = 0; k < len; k++) begin
				if (mode < 4 && recent.size() > 8) begin
					// copy from recent history: yields tokens
					src = $urandom_range(0, recent.size() - 1);
					b = recent[src];
				end else if (mode < 7)
					b = $urandom_range(0, 1) ? 8'hFF : 8'h00;
				else
					b = 8'($urandom());
				recent.push_back(b);
				if (recent.size() > 48)
					void'(recent.pop_front());
				// mostly well-formed streams; now and then an early flush
				send_word(b, (k == len - 1) || ($urandom_range(0, 29) == 0), 1'b1);
				n++;
			end
		end

		// settle: wait for the owed words, then for stray output
		wait_drained();
		repeat (TAIL_CYC) @(negedge clk);
		if (errors == 0)
			$display("tb_lzss_stream_compressor passed");
		else
			$display("tb_lzss_stream_compressor failed");
		$finish;
	end

	// ---------------------------------------------------------------------
	// Receiver: stall bursts at the falling edge, the long hold-off counted
	// down here; check accepted words at the rising edge.
	// ---------------------------------------------------------------------
	int stall_left = 0;

	always @(negedge clk) begin
		if (long_hold > 0) begin
			out_stall <= 1'b1;
			long_hold <= long_hold - 1;
		end else if (stall_left > 0) begin
			out_stall  <= 1'b1;
			stall_left <= stall_left - 1;
		end else if (!quiet_phase && $urandom_range(0, 5) == 0) begin
			out_stall  <= 1'b1;
			stall_left <= $urandom_range(0, 2);
		end else
			out_stall <= 1'b0;
	end

	always @(posedge clk) begin
		cword_t w;
		if (arst_n && out_valid && !out_stall) begin
			if (owed_q.size() == 0)
				report($sformatf("unexpected word %h last %b", out_byte, out_last));
			else begin
				w = owed_q.pop_front();
				if (out_byte !== w.b)
					report($sformatf("out_byte %h, predicted %h", out_byte, w.b));
				if (out_last !== w.last)
					report($sformatf("out_last %b, predicted %b (byte %h)",
						out_last, w.last, w.b));
			end
		end
	end

endmodule

// File: filelist.f
design/lzss_pkg.sv
design/lzss_window.sv
design/lzss_match.sv
design/lzss_group.sv
design/lzss_stream_compressor.sv
tb/sv/tb_lzss_stream_compressor.sv
